@@ rtl/robc_pkg.sv @@
package robc_pkg;

   localparam int VW    = 32;          // coordinate width
   localparam int EW    = 31;          // half extent width
   localparam int TW    = 31;          // ray parameter width
   localparam int FRAC  = 16;          // fraction bits
   localparam int PW    = 2 * VW + 1;  // product width
   localparam int DW    = 52;          // dot, numerator and denominator width (signed)
   localparam int MW    = DW;          // magnitude width
   localparam int RW    = MW + 1;      // divider partial remainder width
   localparam int XW    = MW + FRAC;   // shifted dividend width
   localparam int QW    = TW;          // quotient bits
   localparam int NEDGE = 4;

   localparam logic [TW-1:0] T_MAX = '1;

   typedef struct packed {
      logic signed [VW-1:0] origin_x;
      logic signed [VW-1:0] origin_y;
      logic signed [VW-1:0] dir_x;
      logic signed [VW-1:0] dir_y;
      logic signed [VW-1:0] center_x;
      logic signed [VW-1:0] center_y;
      logic signed [VW-1:0] axis0_x;
      logic signed [VW-1:0] axis0_y;
      logic signed [VW-1:0] axis1_x;
      logic signed [VW-1:0] axis1_y;
      logic [EW-1:0]        half_extent0;
      logic [EW-1:0]        half_extent1;
   } req_type;

   typedef struct packed {
      logic          hit;
      logic [TW-1:0] hit_distance;
   } rsp_type;

   typedef struct packed {
      logic          den_pos;
      logic          den_neg;
      logic          num_pos;
      logic          num_zero;
      logic [MW-1:0] mag_n;
      logic [MW-1:0] mag_d;
   } edge_type;

   typedef struct packed {
      logic          den_pos;
      logic          den_neg;
      logic          num_pos;
      logic          num_zero;
      logic          big;
      logic          rem;
      logic [QW-1:0] q;
   } quot_type;

endpackage

@@ rtl/ray_oriented_box_clip_core.sv @@
// Pipeline from an accepted request beat to rsp_valid: 5 transform stages,
// 32 divider stages (a 31-step restoring divider per edge sets the depth),
// 2 clip stages, output register. Throughput: one beat per cycle unless stalled.
// req_stall rises only when the two-entry output buffer is full.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
module ray_oriented_box_clip_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  robc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output robc_pkg::rsp_type rsp_data
);
   localparam int NEDGE = robc_pkg::NEDGE;

   logic                           en;
   logic                           xf_valid, dv_valid, cl_valid;
   robc_pkg::edge_type [NEDGE-1:0] xf_edge;
   robc_pkg::quot_type [NEDGE-1:0] dv_quot;
   robc_pkg::rsp_type              cl_rsp;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   robc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   robc_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              arrive, take;

   // pipeline runs whenever the skid entry is free
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   robc_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .out_valid (xf_valid),
      .out_edge  (xf_edge)
   );

   robc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xf_valid),
      .in_edge   (xf_edge),
      .out_valid (dv_valid),
      .out_quot  (dv_quot)
   );

   robc_clip u_clip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (dv_valid),
      .in_quot   (dv_quot),
      .out_valid (cl_valid),
      .out_rsp   (cl_rsp)
   );

   assign arrive = cl_valid && en;
   assign take   = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = cl_rsp;
         end else begin
            // hold the waiting beat, park the new one
            skid_valid_in = 1'b1;
            skid_data_in  = cl_rsp;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/robc_xform.sv @@
module robc_xform (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         en,
   input  logic                                         in_valid,
   input  robc_pkg::req_type                            in_req,
   output logic                                         out_valid,
   output robc_pkg::edge_type [robc_pkg::NEDGE-1:0]     out_edge
);
   localparam int VW    = robc_pkg::VW;
   localparam int EW    = robc_pkg::EW;
   localparam int PW    = robc_pkg::PW;
   localparam int DW    = robc_pkg::DW;
   localparam int FRAC  = robc_pkg::FRAC;
   localparam int NEDGE = robc_pkg::NEDGE;

   // stage 1: origin relative to box center
   logic signed [VW:0]   px_in, py_in, px_ff, py_ff;
   logic signed [VW-1:0] dx_ff, dy_ff, a0x_ff, a0y_ff, a1x_ff, a1y_ff;
   logic [EW-1:0]        e0_1_ff, e1_1_ff;
   // stage 2: products
   logic signed [PW-1:0] pox0_ff, poy0_ff, pox1_ff, poy1_ff;
   logic signed [PW-1:0] pdx0_ff, pdy0_ff, pdx1_ff, pdy1_ff;
   logic [EW-1:0]        e0_2_ff, e1_2_ff;
   // stage 3: box-space origin and direction
   logic signed [DW-1:0] bo0_in, bo1_in, bd0_in, bd1_in;
   logic signed [DW-1:0] bo0_ff, bo1_ff, bd0_ff, bd1_ff;
   logic [EW-1:0]        e0_3_ff, e1_3_ff;
   // stage 4: edge numerators and denominators
   logic signed [DW-1:0] num_in [NEDGE];
   logic signed [DW-1:0] den_in [NEDGE];
   logic signed [DW-1:0] num_ff [NEDGE];
   logic signed [DW-1:0] den_ff [NEDGE];
   // stage 5: signs and magnitudes
   robc_pkg::edge_type [NEDGE-1:0] edge_in, edge_ff;
   logic [4:0] v_ff;

   function automatic logic signed [DW-1:0] floor_q(input logic signed [PW-1:0] p);
      floor_q = {{(DW-(PW-FRAC)){p[PW-1]}}, p[PW-1:FRAC]};
   endfunction

   assign px_in = {in_req.origin_x[VW-1], in_req.origin_x}
                - {in_req.center_x[VW-1], in_req.center_x};
   assign py_in = {in_req.origin_y[VW-1], in_req.origin_y}
                - {in_req.center_y[VW-1], in_req.center_y};

   assign bo0_in = floor_q(pox0_ff) + floor_q(poy0_ff);
   assign bo1_in = floor_q(pox1_ff) + floor_q(poy1_ff);
   assign bd0_in = floor_q(pdx0_ff) + floor_q(pdy0_ff);
   assign bd1_in = floor_q(pdx1_ff) + floor_q(pdy1_ff);

   always_comb begin
      logic signed [DW-1:0] e0x, e1x;
      e0x = {{(DW-EW){1'b0}}, e0_3_ff};
      e1x = {{(DW-EW){1'b0}}, e1_3_ff};
      num_in[0] = -bo0_ff - e0x;
      num_in[1] =  bo0_ff - e0x;
      num_in[2] = -bo1_ff - e1x;
      num_in[3] =  bo1_ff - e1x;
      den_in[0] =  bd0_ff;
      den_in[1] = -bd0_ff;
      den_in[2] =  bd1_ff;
      den_in[3] = -bd1_ff;
   end

   always_comb begin
      for (int l = 0; l < NEDGE; l++) begin
         edge_in[l].den_neg  = den_ff[l][DW-1];
         edge_in[l].den_pos  = !den_ff[l][DW-1] && (den_ff[l] != '0);
         edge_in[l].num_zero = (num_ff[l] == '0);
         edge_in[l].num_pos  = !num_ff[l][DW-1] && (num_ff[l] != '0);
         edge_in[l].mag_n    = num_ff[l][DW-1] ? -num_ff[l] : num_ff[l];
         edge_in[l].mag_d    = den_ff[l][DW-1] ? -den_ff[l] : den_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         dx_ff   <= in_req.dir_x;
         dy_ff   <= in_req.dir_y;
         a0x_ff  <= in_req.axis0_x;
         a0y_ff  <= in_req.axis0_y;
         a1x_ff  <= in_req.axis1_x;
         a1y_ff  <= in_req.axis1_y;
         e0_1_ff <= in_req.half_extent0;
         e1_1_ff <= in_req.half_extent1;

         pox0_ff <= px_ff * a0x_ff;
         poy0_ff <= py_ff * a0y_ff;
         pox1_ff <= px_ff * a1x_ff;
         poy1_ff <= py_ff * a1y_ff;
         pdx0_ff <= dx_ff * a0x_ff;
         pdy0_ff <= dy_ff * a0y_ff;
         pdx1_ff <= dx_ff * a1x_ff;
         pdy1_ff <= dy_ff * a1y_ff;
         e0_2_ff <= e0_1_ff;
         e1_2_ff <= e1_1_ff;

         bo0_ff  <= bo0_in;
         bo1_ff  <= bo1_in;
         bd0_ff  <= bd0_in;
         bd1_ff  <= bd1_in;
         e0_3_ff <= e0_2_ff;
         e1_3_ff <= e1_2_ff;

         for (int l = 0; l < NEDGE; l++) begin
            num_ff[l] <= num_in[l];
            den_ff[l] <= den_in[l];
         end

         edge_ff <= edge_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_edge  = edge_ff;

endmodule

@@ rtl/robc_div.sv @@
module robc_div (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  robc_pkg::edge_type [robc_pkg::NEDGE-1:0]  in_edge,
   output logic                                      out_valid,
   output robc_pkg::quot_type [robc_pkg::NEDGE-1:0]  out_quot
);
   localparam int MW    = robc_pkg::MW;
   localparam int RW    = robc_pkg::RW;
   localparam int XW    = robc_pkg::XW;
   localparam int QW    = robc_pkg::QW;
   localparam int FRAC  = robc_pkg::FRAC;
   localparam int SH    = QW - FRAC;
   localparam int NEDGE = robc_pkg::NEDGE;
   localparam int NST   = QW + 1;

   typedef struct packed {
      logic          den_pos;
      logic          den_neg;
      logic          num_pos;
      logic          num_zero;
      logic          big;
      logic [XW-1:0] x;
      logic [MW-1:0] d;
      logic [RW-1:0] r;
      logic [QW-1:0] q;
   } lane_type;

   lane_type [NEDGE-1:0] st_in [NST];
   lane_type [NEDGE-1:0] st_ff [NST];
   logic [NST-1:0]       v_ff;

   always_comb begin
      for (int l = 0; l < NEDGE; l++) begin
         st_in[0][l].den_pos  = in_edge[l].den_pos;
         st_in[0][l].den_neg  = in_edge[l].den_neg;
         st_in[0][l].num_pos  = in_edge[l].num_pos;
         st_in[0][l].num_zero = in_edge[l].num_zero;
         // quotient of 2^31 or more saturates
         st_in[0][l].big = {{SH{1'b0}}, in_edge[l].mag_n} >= {in_edge[l].mag_d, {SH{1'b0}}};
         st_in[0][l].x   = {in_edge[l].mag_n, {FRAC{1'b0}}};
         st_in[0][l].d   = in_edge[l].mag_d;
         st_in[0][l].r   = {{(RW-(MW-SH)){1'b0}}, in_edge[l].mag_n[MW-1:SH]};
         st_in[0][l].q   = '0;
      end
      // one restoring step per stage, quotient bit QW-k
      for (int k = 1; k < NST; k++) begin
         for (int l = 0; l < NEDGE; l++) begin
            st_in[k][l]   = st_ff[k-1][l];
            st_in[k][l].r = {st_ff[k-1][l].r[RW-2:0], st_ff[k-1][l].x[QW-k]};
            if (st_in[k][l].r >= {1'b0, st_ff[k-1][l].d}) begin
               st_in[k][l].r       = st_in[k][l].r - {1'b0, st_ff[k-1][l].d};
               st_in[k][l].q[QW-k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NST; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < NEDGE; l++) begin
         out_quot[l].den_pos  = st_ff[NST-1][l].den_pos;
         out_quot[l].den_neg  = st_ff[NST-1][l].den_neg;
         out_quot[l].num_pos  = st_ff[NST-1][l].num_pos;
         out_quot[l].num_zero = st_ff[NST-1][l].num_zero;
         out_quot[l].big      = st_ff[NST-1][l].big;
         out_quot[l].rem      = |st_ff[NST-1][l].r;
         out_quot[l].q        = st_ff[NST-1][l].q;
      end
   end

   assign out_valid = v_ff[NST-1];

endmodule

@@ rtl/robc_clip.sv @@
module robc_clip (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  robc_pkg::quot_type [robc_pkg::NEDGE-1:0]  in_quot,
   output logic                                      out_valid,
   output robc_pkg::rsp_type                         out_rsp
);
   localparam int TW = robc_pkg::TW;

   typedef struct packed {
      logic          alive;
      logic          t1_inf;
      logic [TW-1:0] t0;
      logic [TW-1:0] t1;
   } clip_state_type;

   // num * 2^16 > den * t for a positive denominator
   function automatic logic gt_pos(input robc_pkg::quot_type e, input logic [TW-1:0] t);
      gt_pos = e.num_pos && (e.big || (e.q > t) || ((e.q == t) && e.rem));
   endfunction

   // num * 2^16 > den * t for a negative denominator
   function automatic logic gt_neg(input robc_pkg::quot_type e, input logic [TW-1:0] t);
      gt_neg = e.num_pos || (e.num_zero && (t != '0))
            || (!e.num_pos && !e.num_zero && !e.big && (e.q < t));
   endfunction

   function automatic clip_state_type clip_edge(input clip_state_type s,
                                                input robc_pkg::quot_type e);
      clip_state_type o;
      logic [TW-1:0]  qs;
      o  = s;
      qs = e.big ? robc_pkg::T_MAX : e.q;
      if (s.alive) begin
         if (e.den_pos) begin
            if (!s.t1_inf && gt_pos(e, s.t1)) begin
               o.alive = 1'b0;
            end else if (gt_pos(e, s.t0)) begin
               o.t0 = qs;
            end
         end else if (e.den_neg) begin
            if (gt_neg(e, s.t0)) begin
               o.alive = 1'b0;
            end else if (s.t1_inf || gt_neg(e, s.t1)) begin
               o.t1     = qs;
               o.t1_inf = 1'b0;
            end
         end else if (e.num_pos) begin
            // parallel edge with the origin outside
            o.alive = 1'b0;
         end
      end
      clip_edge = o;
   endfunction

   clip_state_type     init_state, sa_in, sa_ff, sb_in;
   robc_pkg::quot_type q2_ff, q3_ff;
   robc_pkg::rsp_type  rsp_in, rsp_ff;
   logic               va_ff, vb_ff;

   assign init_state = '{alive: 1'b1, t1_inf: 1'b1, t0: '0, t1: robc_pkg::T_MAX};
   assign sa_in = clip_edge(clip_edge(init_state, in_quot[0]), in_quot[1]);
   assign sb_in = clip_edge(clip_edge(sa_ff, q2_ff), q3_ff);

   always_comb begin
      rsp_in.hit          = sb_in.alive;
      rsp_in.hit_distance = sb_in.alive ? sb_in.t0 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff  <= sa_in;
         q2_ff  <= in_quot[2];
         q3_ff  <= in_quot[3];
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_rsp   = rsp_ff;

endmodule

@@ rtl/robc_checker.sv @@
module robc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input robc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input robc_pkg::rsp_type rsp_data
);

   // a stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("req beat changed under stall");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");

   // a miss always reports zero distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.hit_distance == '0)
      else $error("miss with nonzero distance");

   // reset empties the output side
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // reset leaves the input side open
   a_reset_req: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("req_stall after reset");

endmodule

bind ray_oriented_box_clip_core robc_checker u_robc_checker (.*);
